@@ rtl/hamming_nearest_neighbor_vote_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Hamming nearest-neighbour vote block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef HAMMING_NEAREST_NEIGHBOR_VOTE_ASSERT_SVH
`define HAMMING_NEAREST_NEIGHBOR_VOTE_ASSERT_SVH

`ifndef ASSERT_OFF
// cond holds in the same cycle as trig
`define HNNV_ASSERT_IMPLIES(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");
// cond holds in the cycle after trig
`define HNNV_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
// cond never holds
`define HNNV_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define HNNV_ASSERT_IMPLIES(lbl, clk, rst, trig, cond)
`define HNNV_ASSERT_NEXT(lbl, clk, rst, trig, cond)
`define HNNV_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ rtl/hnnv_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnnv_pkg
// Shared constants, codes and types of the nearest-neighbour vote block.
// ---------------------------------------------------------------------------
package hnnv_pkg;

   localparam int DEF_MAX_ENTRIES  = 1024;
   localparam int DEF_FEATURE_BITS = 64;

   localparam int FEATURES_W = 64;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int VOTE_W     = 12;
   localparam int MIN_DIST_W = 7;

   // bits of the difference vector counted by one cell
   localparam int CELL_BITS = 8;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
   // any command with this bit set is a query
   localparam int CMD_QUERY_BIT = 1;

   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ANSWER  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

   // side information that travels with an entry down the cell chain
   typedef struct packed {
      logic valid;
      logic last;
      logic label;
   } hnnv_tag_type;

endpackage

@@ rtl/hnnv_ifs.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnnv request and response channels
// Valid/ready channels carrying requests and their results.
// ---------------------------------------------------------------------------
interface hnnv_req_if import hnnv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [FEATURES_W-1:0] features;
   logic                  label_positive;

   modport source (output valid, command, features, label_positive, input ready);
   modport sink   (input valid, command, features, label_positive, output ready);
endinterface

interface hnnv_rsp_if import hnnv_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic signed [VOTE_W-1:0]     vote;
   logic [MIN_DIST_W-1:0]        min_distance;

   modport source (output valid, status, vote, min_distance, input ready);
   modport sink   (input valid, status, vote, min_distance, output ready);
endinterface

@@ rtl/hnnv_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnnv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module hnnv_ram #(
   parameter int WIDTH  = 65,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/hnnv_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnnv_cell
// One link of the distance chain: counts the set bits of its slice of the
// difference vector, adds them to the running distance and passes it on.
// ---------------------------------------------------------------------------
module hnnv_cell import hnnv_pkg::*; #(
   parameter int DIFF_W = 64,
   parameter int DIST_W = 7,
   parameter int SLICE  = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  hnnv_tag_type       in_tag,
   input  logic [DIFF_W-1:0]  in_diff,
   input  logic [DIST_W-1:0]  in_dist,
   output hnnv_tag_type       out_tag,
   output logic [DIFF_W-1:0]  out_diff,
   output logic [DIST_W-1:0]  out_dist
);

   hnnv_tag_type      tag_ff;
   logic [DIFF_W-1:0] diff_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;

   always_comb begin
      dist_in = in_dist;
      for (int i = 0; i < CELL_BITS; i++) begin
         dist_in = dist_in + DIST_W'(in_diff[SLICE*CELL_BITS + i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= in_diff;
      dist_ff <= dist_in;
   end

   assign out_tag  = tag_ff;
   assign out_diff = diff_ff;
   assign out_dist = dist_ff;

endmodule

@@ rtl/hamming_nearest_neighbor_vote.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hamming_nearest_neighbor_vote
// Stores labelled binary vectors; answers a query with the smallest Hamming
// distance to the store and the label vote of the entries at that distance.
// ---------------------------------------------------------------------------
//  channel    direction  payload
//  req_chan   in         command, features, label_positive
//  rsp_chan   out        status, vote, min_distance
//
//  One request at a time. For a query the store RAM is read one entry a
//  cycle and each entry walks a chain of 8-bit popcount cells.
//  Reset empties the store at once; no clearing pass is needed.
//  A result waiting on rsp_chan does not stop the next request being taken;
//  only the hand-over of a finished result waits for the output register.
// ---------------------------------------------------------------------------
`include "hamming_nearest_neighbor_vote_assert.svh"

module hamming_nearest_neighbor_vote import hnnv_pkg::*; #(
   parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
   parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   hnnv_req_if.sink   req_chan,
   hnnv_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int NCELL  = (FEATURE_BITS + CELL_BITS - 1) / CELL_BITS;
   localparam int DIFF_W = NCELL * CELL_BITS;
   localparam int DIST_W = $clog2(FEATURE_BITS + 1);
   localparam int RAM_W  = FEATURE_BITS + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic                    issue_ff, issue_in;
   logic                    rd_vld_ff, rd_last_ff;
   logic                    first_ff, first_in;
   logic [DIST_W-1:0]       best_ff, best_in;
   logic [VOTE_W-1:0]       tally_ff, tally_in;
   logic [FEATURE_BITS-1:0] query_ff, query_in;
   logic [STATUS_W-1:0]     pend_status_ff, pend_status_in;
   logic [VOTE_W-1:0]       pend_vote_ff, pend_vote_in;
   logic [DIST_W-1:0]       pend_dist_ff, pend_dist_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [VOTE_W-1:0]       rsp_vote_ff, rsp_vote_in;
   logic [DIST_W-1:0]       rsp_dist_ff, rsp_dist_in;

   logic               req_fire;
   logic               full;
   logic               issue_last;
   logic               ram_wr_en;
   logic [RAM_W-1:0]   ram_rd_data;
   logic [VOTE_W-1:0]  label_step;

   hnnv_tag_type       tag_chain  [NCELL+1];
   logic [DIFF_W-1:0]  diff_chain [NCELL+1];
   logic [DIST_W-1:0]  dist_chain [NCELL+1];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(MAX_ENTRIES));
   assign issue_last     = (CNT_W'(rd_addr_ff) == count_ff - CNT_W'(1));
   assign ram_wr_en      = req_fire && !req_chan.command[CMD_QUERY_BIT]
                           && (req_chan.command == CMD_LOAD) && !full;

   hnnv_ram #(
      .WIDTH  (RAM_W),
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_chan.label_positive, req_chan.features[FEATURE_BITS-1:0]}),
      .rd_en   (issue_ff),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // feed the chain with the difference of the entry just read
   assign tag_chain[0]  = '{valid: rd_vld_ff, last: rd_last_ff,
                            label: ram_rd_data[FEATURE_BITS]};
   assign diff_chain[0] = DIFF_W'(ram_rd_data[FEATURE_BITS-1:0] ^ query_ff);
   assign dist_chain[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      hnnv_cell #(
         .DIFF_W (DIFF_W),
         .DIST_W (DIST_W),
         .SLICE  (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_tag   (tag_chain[k]),
         .in_diff  (diff_chain[k]),
         .in_dist  (dist_chain[k]),
         .out_tag  (tag_chain[k+1]),
         .out_diff (diff_chain[k+1]),
         .out_dist (dist_chain[k+1])
      );
   end

   assign label_step = tag_chain[NCELL].label ? VOTE_W'(1) : '1;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_addr_in     = rd_addr_ff;
      issue_in       = issue_ff;
      first_in       = first_ff;
      best_in        = best_ff;
      tally_in       = tally_ff;
      query_in       = query_ff;
      pend_status_in = pend_status_ff;
      pend_vote_in   = pend_vote_ff;
      pend_dist_in   = pend_dist_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_vote_in    = rsp_vote_ff;
      rsp_dist_in    = rsp_dist_ff;

      // drop the held result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pend_vote_in = '0;
               pend_dist_in = '0;
               state_in     = S_DONE;
               if (req_chan.command[CMD_QUERY_BIT]) begin
                  if (count_ff == '0) begin
                     pend_status_in = ST_EMPTY;
                  end else begin
                     query_in   = req_chan.features[FEATURE_BITS-1:0];
                     rd_addr_in = '0;
                     issue_in   = 1'b1;
                     first_in   = 1'b1;
                     state_in   = S_SCAN;
                  end
               end else if (req_chan.command == CMD_LOAD) begin
                  if (full) begin
                     pend_status_in = ST_FULL;
                  end else begin
                     pend_status_in = ST_LOADED;
                     count_in       = count_ff + CNT_W'(1);
                  end
               end else begin
                  pend_status_in = ST_CLEARED;
                  count_in       = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               if (issue_last) begin
                  issue_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + ADDR_W'(1);
               end
            end
            if (tag_chain[NCELL].valid) begin
               if (first_ff || (dist_chain[NCELL] < best_ff)) begin
                  best_in  = dist_chain[NCELL];
                  tally_in = label_step;
                  first_in = 1'b0;
               end else if (dist_chain[NCELL] == best_ff) begin
                  tally_in = tally_ff + label_step;
               end
               if (tag_chain[NCELL].last) begin
                  pend_status_in = ST_ANSWER;
                  pend_vote_in   = tally_in;
                  pend_dist_in   = best_in;
                  state_in       = S_DONE;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_vote_in   = pend_vote_ff;
               rsp_dist_in   = pend_dist_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= issue_ff;
         rd_last_ff   <= issue_ff && issue_last;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      first_ff       <= first_in;
      best_ff        <= best_in;
      tally_ff       <= tally_in;
      query_ff       <= query_in;
      pend_status_ff <= pend_status_in;
      pend_vote_ff   <= pend_vote_in;
      pend_dist_ff   <= pend_dist_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_vote_ff    <= rsp_vote_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.vote         = rsp_vote_ff;
   assign rsp_chan.min_distance = MIN_DIST_W'(rsp_dist_ff);

   `HNNV_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(MAX_ENTRIES))
   `HNNV_ASSERT_NEVER(a_chain_only_in_scan, clock, reset,
      tag_chain[NCELL].valid && (state_ff != S_SCAN))
   `HNNV_ASSERT_NEXT(a_empty_query, clock, reset,
      req_fire && req_chan.command[CMD_QUERY_BIT] && (count_ff == '0),
      (state_ff == S_DONE) && (pend_status_ff == ST_EMPTY))
   `HNNV_ASSERT_IMPLIES(a_dist_range, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_ANSWER),
      rsp_dist_ff <= DIST_W'(FEATURE_BITS))

endmodule
